// ----- rtl/banded_bitmap_sector_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef BANDED_BITMAP_SECTOR_ALLOCATOR_DEFINES_SVH
`define BANDED_BITMAP_SECTOR_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BBSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BBSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bbsa_pkg.sv -----
// Types, codes and byte helpers of the banded bitmap sector allocator.
package bbsa_pkg;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] goal_sector;
    logic [12:0] request_count;
    logic [12:0] byte_index;
    logic [7:0]  byte_value;
  } bbsa_in_t;

  typedef struct packed {
    logic [15:0] start_sector;
    logic [12:0] granted_count;
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [16:0] free_count;
  } bbsa_out_t;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BITMAP  = 2'd2;
  localparam logic [1:0] ST_ZONE    = 2'd3;

  localparam logic [2:0] REG_BAND_COUNT   = 3'd0;
  localparam logic [2:0] REG_LOG2_BAND    = 3'd1;
  localparam logic [2:0] REG_ROOT         = 3'd2;
  localparam logic [2:0] REG_TOTAL        = 3'd3;
  localparam logic [2:0] REG_BITMAP_AREA  = 3'd4;
  localparam logic [2:0] REG_INITIAL_FREE = 3'd5;

  // Mask of the bits below a start position: those count as used.
  function automatic logic [7:0] low_mask(input logic [2:0] s);
    low_mask = 8'((9'd1 << s) - 9'd1);
  endfunction

  // Position of the lowest zero bit of a byte (7 when there is none).
  function automatic logic [2:0] first_zero(input logic [7:0] m);
    logic [2:0] idx;
    idx = 3'd7;
    for (int j = 7; j >= 0; j--) begin
      if (!m[j]) begin
        idx = 3'(j);
      end
    end
    first_zero = idx;
  endfunction

endpackage

// ----- rtl/bbsa_ram.sv -----
// Generic single-port RAM with registered read data.
module bbsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- rtl/banded_bitmap_sector_allocator.sv -----
// Banded bitmap sector allocator: top level with sequencer and bitmap store.
//
// Usage. Words enter on the in channel (in_valid_i / in_ready_o, payload
// in_data_i) and each one produces exactly one word on the out channel
// (out_valid_o / out_ready_i, payload out_data_o). Command 0 allocates a run
// of free sectors near a goal, command 1 writes one bitmap byte, command 2
// reads one back, and command 3 only reports the free counter.
// Configuration registers are written on the cfg channel, which is always
// ready; writes are expected only while the block is idle.
// Flow. The bitmap RAM has a registered read, so every byte visited passes
// through an address state and then an evaluate state. A byte write or read
// visits one byte; an allocation visits every byte it scans and every byte it
// claims, and the worst case scans every band of the volume twice, so the cost is
// set by the band size and band count. One word is in flight at a time.
// Reset. After rst_ni is released the block sweeps the whole bitmap RAM to
// zero, one byte per cycle, with in_ready_o low; configuration writes are
// accepted during the sweep.
// Stalls. The result sits in an output register; while the receiver holds
// out_ready_i low the block finishes its work and then waits to hand over.
module banded_bitmap_sector_allocator #(
  parameter int MAX_BANDS        = 16,
  parameter int MAX_BAND_SECTORS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bbsa_pkg::bbsa_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bbsa_pkg::bbsa_out_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i
);
  import bbsa_pkg::*;

`include "banded_bitmap_sector_allocator_defines.svh"

  // Derived sizes. LGMAX is log2 of the largest band; BYW holds a byte
  // position inside a band and also the byte count of the largest band.
  localparam int STORE_BYTES = MAX_BANDS * MAX_BAND_SECTORS / 8;
  localparam int AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int LGMAX = $clog2(MAX_BAND_SECTORS);
  localparam int BYW   = LGMAX - 2;
  localparam int BNW   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int NBW   = $clog2(MAX_BANDS + 1);
  localparam int RW    = BNW + LGMAX + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_GOAL = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EV   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // What the current byte visit is for.
  localparam logic [2:0] M_BITS  = 3'd0;
  localparam logic [2:0] M_ZB    = 3'd1;
  localparam logic [2:0] M_CLAIM = 3'd2;
  localparam logic [2:0] M_WR    = 3'd3;
  localparam logic [2:0] M_RD    = 3'd4;

  // Configuration registers.
  logic [4:0]  band_count_q;
  logic [3:0]  log2_band_q;
  logic [15:0] root_q;
  logic [16:0] total_q;
  logic [12:0] area_q;
  logic [16:0] free_q, free_d;

  // Sequencer state.
  logic [2:0]     state_q, state_d;
  logic [2:0]     mode_q, mode_d;
  logic [AW-1:0]  clr_q, clr_d;
  bbsa_in_t       item_q;
  logic           inr_q;
  logic [BNW-1:0] band_q, band_d;
  logic [NBW-1:0] tries_q, tries_d;
  logic [BYW-1:0] b_q, b_d;
  logic [2:0]     s_q, s_d;
  logic           second_q, second_d;
  logic [LGMAX-1:0] p_q, p_d;
  logic [12:0]    got_q, got_d;
  logic           found_q, found_d;
  logic [7:0]     rbyte_q, rbyte_d;

  bbsa_out_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  // RAM port.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  bbsa_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Effective geometry: the band count and band size are clamped to what
  // the store can hold.
  logic [4:0]       lg_eff;
  logic [4:0]       lgm3;
  logic [NBW-1:0]   nb_eff;
  logic [BYW-1:0]   bytes_cur;
  logic             last_byte;

  always_comb begin
    if (log2_band_q < 4'd3) begin
      lg_eff = 5'd3;
    end else if (32'(log2_band_q) > LGMAX) begin
      lg_eff = 5'(LGMAX);
    end else begin
      lg_eff = 5'(log2_band_q);
    end
    if (band_count_q == 5'd0) begin
      nb_eff = NBW'(1);
    end else if (32'(band_count_q) > MAX_BANDS) begin
      nb_eff = NBW'(MAX_BANDS);
    end else begin
      nb_eff = NBW'(band_count_q);
    end
    lgm3      = lg_eff - 5'd3;
    bytes_cur = BYW'(1) << lgm3;
    last_byte = (32'(b_q) + 1) == 32'(bytes_cur);
  end

  // Goal handling: a goal at or below root, or past the total, falls back to
  // root; a band number past the band count wraps to band zero.
  logic [15:0]      goal;
  logic [15:0]      goal_band;
  logic [LGMAX-1:0] goal_off;

  always_comb begin
    if (item_q.goal_sector <= root_q || {1'b0, item_q.goal_sector} > total_q) begin
      goal = root_q;
    end else begin
      goal = item_q.goal_sector;
    end
    goal_band = 16'(goal >> lg_eff);
    goal_off  = LGMAX'(32'(goal) & ((32'd1 << lg_eff) - 32'd1));
  end

  // Per-byte evaluation: bit scan, zero-byte test and run claiming.
  logic [7:0] scan_m;
  logic       scan_hit;
  logic [2:0] scan_idx;
  logic [12:0] rem;
  logic [3:0] rem8;
  logic [7:0] claim_byte;
  logic [3:0] claim_k;
  logic       claim_stop;

  always_comb begin
    scan_m   = ram_rdata | low_mask(s_q);
    scan_hit = scan_m != 8'hFF;
    scan_idx = first_zero(scan_m);
    rem      = item_q.request_count - got_q;
    rem8     = (rem >= 13'd8) ? 4'd8 : rem[3:0];
    claim_byte = ram_rdata;
    claim_k    = 4'd0;
    claim_stop = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (3'(j) >= s_q && !claim_stop) begin
        if (ram_rdata[j] || claim_k == rem8) begin
          claim_stop = 1'b1;
        end else begin
          claim_byte[j] = 1'b1;
          claim_k       = claim_k + 4'd1;
        end
      end
    end
  end

  // Allocation outcome, formed when the result is handed over.
  logic [RW-1:0] ret;
  logic [RW:0]   ret_end;
  logic [1:0]    alloc_status;

  always_comb begin
    ret     = RW'(p_q) + (RW'(band_q) << lg_eff);
    ret_end = (RW + 1)'(ret) + (RW + 1)'(got_q);
    if (32'(p_q) < 32'(area_q)) begin
      alloc_status = ST_BITMAP;
    end else if (32'(ret_end) > 32'(total_q) || 32'(ret) <= 32'(root_q)) begin
      alloc_status = ST_ZONE;
    end else begin
      alloc_status = ST_OK;
    end
  end

  // RAM address and write control.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = item_q.byte_value;
    if (mode_q == M_WR || mode_q == M_RD) begin
      ram_addr = AW'(item_q.byte_index);
    end else begin
      ram_addr = (AW'(band_q) << lgm3) + AW'(b_q);
    end
    case (state_q)
      S_CLR: begin
        ram_addr  = clr_q;
        ram_we    = 1'b1;
        ram_wdata = 8'd0;
      end
      S_RD: begin
        ram_we = (mode_q == M_WR) && inr_q;
      end
      S_EV: begin
        if (mode_q == M_CLAIM) begin
          ram_we    = 1'b1;
          ram_wdata = claim_byte;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    clr_d       = clr_q;
    band_d      = band_q;
    tries_d     = tries_q;
    b_d         = b_q;
    s_d         = s_q;
    second_d    = second_q;
    p_d         = p_q;
    got_d       = got_q;
    found_d     = found_q;
    rbyte_d     = rbyte_q;
    free_d      = free_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      S_CLR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          found_d = 1'b0;
          rbyte_d = 8'd0;
          case (in_data_i.cmd)
            CMD_ALLOC: state_d = S_GOAL;
            CMD_WRITE: begin
              mode_d  = M_WR;
              state_d = S_RD;
            end
            CMD_READ: begin
              mode_d  = M_RD;
              state_d = S_RD;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_GOAL: begin
        tries_d  = '0;
        second_d = 1'b0;
        got_d    = 13'd0;
        if (32'(goal_band) >= 32'(nb_eff)) begin
          band_d = '0;
        end else begin
          band_d = BNW'(goal_band);
        end
        if (goal_off != '0) begin
          mode_d = M_BITS;
          b_d    = BYW'(goal_off >> 3);
          s_d    = goal_off[2:0];
        end else begin
          mode_d = M_ZB;
          b_d    = '0;
          s_d    = 3'd0;
        end
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        state_d = S_RD;
        case (mode_q)
          M_WR: state_d = S_OUT;
          M_RD: begin
            if (inr_q) begin
              rbyte_d = ram_rdata;
            end
            state_d = S_OUT;
          end
          M_CLAIM: begin
            got_d = got_q + 13'(claim_k);
            if (claim_stop || last_byte) begin
              found_d = 1'b1;
              state_d = S_OUT;
            end else begin
              b_d = b_q + BYW'(1);
              s_d = 3'd0;
            end
          end
          default: begin
            // Bit scan or zero-byte search over the current band.
            logic       hit;
            logic [2:0] bit_pos;
            hit     = (mode_q == M_BITS) ? scan_hit : (ram_rdata == 8'd0);
            bit_pos = (mode_q == M_BITS) ? scan_idx : 3'd0;
            if (hit) begin
              p_d = LGMAX'({b_q, bit_pos});
              if ({b_q, bit_pos} != '0) begin
                mode_d = M_CLAIM;
                s_d    = bit_pos;
              end
            end else if (!last_byte) begin
              b_d = b_q + BYW'(1);
              s_d = 3'd0;
            end else if (!second_q) begin
              mode_d   = (mode_q == M_BITS) ? M_ZB : M_BITS;
              second_d = 1'b1;
              b_d      = '0;
              s_d      = 3'd0;
            end
            // A band fails when nothing is found, or only position zero.
            if ((hit && {b_q, bit_pos} == '0) || (!hit && last_byte && second_q)) begin
              tries_d  = tries_q + NBW'(1);
              mode_d   = M_ZB;
              second_d = 1'b0;
              b_d      = '0;
              s_d      = 3'd0;
              if (32'(band_q) + 1 >= 32'(nb_eff)) begin
                band_d = '0;
              end else begin
                band_d = band_q + BNW'(1);
              end
              if (32'(tries_q) + 1 == 32'(nb_eff)) begin
                state_d = S_OUT;
              end
            end
          end
        endcase
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d = '0;
          if (item_q.cmd == CMD_ALLOC) begin
            if (!found_q) begin
              out_d.status = ST_NOSPACE;
            end else begin
              out_d.start_sector  = 16'(ret);
              out_d.granted_count = got_q;
              out_d.status        = alloc_status;
              if (alloc_status == ST_OK) begin
                free_d = ({4'd0, got_q} < free_q) ? free_q - {4'd0, got_q} : 17'd0;
              end
            end
          end
          out_d.read_byte  = rbyte_q;
          out_d.free_count = free_d;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      mode_q       <= M_ZB;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      tries_q      <= '0;
      found_q      <= 1'b0;
      band_count_q <= 5'd16;
      log2_band_q  <= 4'd12;
      root_q       <= 16'd1;
      total_q      <= 17'd65536;
      area_q       <= 13'd1;
      free_q       <= 17'd0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      tries_q     <= tries_d;
      found_q     <= found_d;
      free_q      <= free_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_BAND_COUNT:   band_count_q <= cfg_data_i[4:0];
          REG_LOG2_BAND:    log2_band_q  <= cfg_data_i[3:0];
          REG_ROOT:         root_q       <= cfg_data_i[15:0];
          REG_TOTAL:        total_q      <= cfg_data_i;
          REG_BITMAP_AREA:  area_q       <= cfg_data_i[12:0];
          REG_INITIAL_FREE: free_q       <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_data_i;
      inr_q  <= 32'(in_data_i.byte_index) < STORE_BYTES;
    end
    band_q   <= band_d;
    b_q      <= b_d;
    s_q      <= s_d;
    second_q <= second_d;
    p_q      <= p_d;
    got_q    <= got_d;
    rbyte_q  <= rbyte_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  `BBSA_ASSERT_IMP(a_clear_writes_zero, state_q == S_CLR, ram_we && ram_wdata == 8'd0, "clear pass must write zero")
  `BBSA_ASSERT_IMP(a_byte_in_band, state_q == S_EV && (mode_q == M_BITS || mode_q == M_ZB || mode_q == M_CLAIM), 32'(b_q) < 32'(bytes_cur), "byte position left the band")
  `BBSA_ASSERT_IMP(a_tries_bounded, state_q == S_RD && (mode_q == M_BITS || mode_q == M_ZB), 32'(tries_q) < 32'(nb_eff), "searched more bands than in use")
  `BBSA_ASSERT_NXT(a_handover, state_q == S_OUT && (!out_valid_q || out_ready_i), out_valid_q && state_q == S_IDLE, "result not handed over")

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the banded bitmap sector allocator.
`timescale 1ns / 1ps

module tb;
  import bbsa_pkg::*;

  localparam int          STORE_BYTES = 8192;
  localparam int          CYCLE_LIMIT = 20000000;
  // Command 3 has no name in the package; it only reports the free counter.
  localparam logic [1:0]  CMD_NOP     = 2'd3;

  // One line of the directed table: a register write or an input word,
  // optionally with an expected result typed in by hand.
  typedef struct {
    bit          is_reg;
    logic [2:0]  reg_idx;
    logic [16:0] reg_val;
    bbsa_in_t    word;
    bit          typed;
    bbsa_out_t   result;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  bbsa_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bbsa_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  // Shadow copy of the allocator state and its registers.
  logic [7:0]  sector_map [STORE_BYTES];
  int          free_left;
  int          cfg_bands, cfg_log2, cfg_root, cfg_total, cfg_area, cfg_init;

  bbsa_out_t   expected_words [$];
  dir_row_t    directed [$];
  int          mismatches;
  int          cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;
  bit          hold_req;

  banded_bitmap_sector_allocator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // The register values are clamped when they are used, not when written.
  function automatic int eff_bands();
    if (cfg_bands < 1) return 1;
    if (cfg_bands > 16) return 16;
    return cfg_bands;
  endfunction

  function automatic int eff_log2();
    if (cfg_log2 < 3) return 3;
    if (cfg_log2 > 12) return 12;
    return cfg_log2;
  endfunction

  // Bits outside the store read as used.
  function automatic bit map_bit_used(int base, int pos);
    int idx;
    idx = base + (pos >> 3);
    if (idx >= STORE_BYTES) return 1'b1;
    return sector_map[idx][pos & 7];
  endfunction

  // Searches one band and claims a run there. A find at band position
  // zero is treated as a miss, and the run stops at a used bit, the band end or the request count.
  function automatic bit claim_in_band(input int band, input int lg, input int off,
                                       input int want, output int pos, output int got);
    int  bits, nbytes, base, p, b, i;
    bit  found;
    bits   = 1 << lg;
    nbytes = bits >> 3;
    base   = band * nbytes;
    found  = 1'b0;
    p      = 0;
    pos    = 0;
    got    = 0;
    if (off != 0) begin
      for (p = off; p < bits; p++) begin
        if (!map_bit_used(base, p)) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        for (b = 0; b < nbytes; b++) begin
          if (base + b < STORE_BYTES && sector_map[base + b] == 8'h00) begin
            p = b * 8;
            found = 1'b1;
            break;
          end
        end
      end
    end else begin
      for (b = 0; b < nbytes; b++) begin
        if (base + b < STORE_BYTES && sector_map[base + b] == 8'h00) begin
          p = b * 8;
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        for (p = 0; p < bits; p++) begin
          if (!map_bit_used(base, p)) begin
            found = 1'b1;
            break;
          end
        end
      end
    end
    if (!found || p == 0) return 1'b0;
    for (i = 0; i < want && p + i < bits; i++) begin
      if (map_bit_used(base, p + i)) break;
      sector_map[base + ((p + i) >> 3)][(p + i) & 7] = 1'b1;
    end
    pos = p;
    got = i;
    return 1'b1;
  endfunction

  // Works out the result of one accepted word and updates the shadow state.
  function automatic bbsa_out_t predict_allocation(bbsa_in_t w);
    bbsa_out_t r;
    int        nb, lg, goal, band, off, pos, got, ret, k;
    bit        ok;
    r = '0;
    case (w.cmd)
      CMD_ALLOC: begin
        nb   = eff_bands();
        lg   = eff_log2();
        goal = w.goal_sector;
        // Goals at or below root, or past the end of the volume, fall back to root.
        if (goal <= cfg_root || goal > cfg_total) goal = cfg_root;
        band = goal >> lg;
        off  = goal & ((1 << lg) - 1);
        ok   = 1'b0;
        pos  = 0;
        got  = 0;
        for (k = 0; k < nb; k++) begin
          if (band >= nb) band = 0;
          if (claim_in_band(band, lg, off, int'(w.request_count), pos, got)) begin
            ok = 1'b1;
            break;
          end
          off = 0;
          band++;
        end
        if (!ok) begin
          r.status = ST_NOSPACE;
        end else begin
          ret             = pos + (band << lg);
          r.start_sector  = ret[15:0];
          r.granted_count = got[12:0];
          if (pos < cfg_area) begin
            r.status = ST_BITMAP;
          end else if (ret + got > cfg_total || ret <= cfg_root) begin
            r.status = ST_ZONE;
          end else begin
            free_left = (free_left > got) ? free_left - got : 0;
          end
        end
      end
      CMD_WRITE: begin
        sector_map[w.byte_index] = w.byte_value;
      end
      CMD_READ: begin
        r.read_byte = sector_map[w.byte_index];
      end
      default: begin
      end
    endcase
    r.free_count = free_left[16:0];
    return r;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [16:0] val);
    case (idx)
      REG_BAND_COUNT:   cfg_bands = val[4:0];
      REG_LOG2_BAND:    cfg_log2  = val[3:0];
      REG_ROOT:         cfg_root  = val[15:0];
      REG_TOTAL:        cfg_total = val;
      REG_BITMAP_AREA:  cfg_area  = val[12:0];
      REG_INITIAL_FREE: begin
        cfg_init  = val;
        free_left = val;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic dir_row_t word_row(logic [1:0] cmd, int goal, int cnt, int idx, int val);
    dir_row_t row;
    row = '{default: '0};
    row.word = '{cmd, goal[15:0], cnt[12:0], idx[12:0], val[7:0]};
    return row;
  endfunction

  function automatic dir_row_t typed_row(dir_row_t row, bbsa_out_t res);
    row.typed  = 1'b1;
    row.result = res;
    return row;
  endfunction

  function automatic dir_row_t reg_row(logic [2:0] idx, int val);
    dir_row_t row;
    row = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val[16:0];
    return row;
  endfunction

  // Offers one word and holds it until it is taken. Unless a random gap is drawn,
  // valid stays high so that a following word can go out on the next cycle without a bubble.
  task automatic send_word(bbsa_in_t w, bit typed, bbsa_out_t typed_res);
    bbsa_out_t predicted;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
    predicted = predict_allocation(w);
    expected_words.push_back(typed ? typed_res : predicted);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Lowers valid and waits until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (expected_words.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one register; valid drops for a cycle before the next write.
  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic report(string field, int exp_val, int act_val);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
  endtask

  task automatic check_word(bbsa_out_t got);
    bbsa_out_t e;
    if (expected_words.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected word, expected none, actual %h", $time, got);
      return;
    end
    e = expected_words.pop_front();
    if (got.start_sector !== e.start_sector)
      report("start_sector", e.start_sector, got.start_sector);
    if (got.granted_count !== e.granted_count)
      report("granted_count", e.granted_count, got.granted_count);
    if (got.status !== e.status) report("status", e.status, got.status);
    if (got.read_byte !== e.read_byte) report("read_byte", e.read_byte, got.read_byte);
    if (got.free_count !== e.free_count) report("free_count", e.free_count, got.free_count);
  endtask

  // Receiver: checks every word taken and decides ready for the next cycle.
  // A hold-off request keeps ready low for a long stretch, counted here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) check_word(out_data);
    if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= 3000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One random word, shaped by the current register settings so that most
  // goals and byte addresses land inside the bands in use.
  function automatic bbsa_in_t random_word();
    bbsa_in_t w;
    int       span, roll, bytes_used;
    span       = eff_bands() << eff_log2();
    bytes_used = span >> 3;
    w          = '0;
    roll       = $urandom_range(99);
    w.cmd      = (roll < 48) ? CMD_ALLOC : (roll < 73) ? CMD_WRITE :
                 (roll < 95) ? CMD_READ : CMD_NOP;
    w.goal_sector = ($urandom_range(9) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, span + 16));
    roll = $urandom_range(99);
    if (roll < 70) w.request_count = 13'($urandom_range(0, 12));
    else if (roll < 90) w.request_count = 13'($urandom_range(0, 1 << eff_log2()));
    else if (roll < 95) w.request_count = 13'd4096;
    else w.request_count = 13'($urandom_range(0, 4096));
    w.byte_index = ($urandom_range(9) == 0) ? 13'($urandom)
                                            : 13'($urandom_range(0, bytes_used - 1));
    roll = $urandom_range(2);
    w.byte_value = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hff : 8'($urandom);
    return w;
  endfunction

  initial begin
    int        n_items;
    bbsa_in_t  w;

    foreach (sector_map[i]) sector_map[i] = 8'h00;
    free_left     = 0;
    cfg_bands     = 16;
    cfg_log2      = 12;
    cfg_root      = 1;
    cfg_total     = 65536;
    cfg_area      = 1;
    cfg_init      = 0;
    mismatches    = 0;
    cycles        = 0;
    hold_left     = 0;
    hold_req      = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 49;

    // Directed table. The first rows run on the reset settings, where the
    // results of reads, byte writes and the unused command are plain.
    directed.push_back(typed_row(word_row(CMD_READ, 0, 0, 0, 0), '{0, 0, ST_OK, 0, 0}));
    directed.push_back(typed_row(word_row(CMD_READ, 0, 0, 8191, 0), '{0, 0, ST_OK, 0, 0}));
    directed.push_back(typed_row(word_row(CMD_WRITE, 0, 0, 0, 255), '{0, 0, ST_OK, 0, 0}));
    directed.push_back(typed_row(word_row(CMD_READ, 0, 0, 0, 0), '{0, 0, ST_OK, 8'hff, 0}));
    directed.push_back(typed_row(word_row(CMD_NOP, 65535, 4096, 8191, 255),
                                 '{0, 0, ST_OK, 0, 0}));
    // Goal below root, a run in the last band clamped at its end, and a
    // zero request on an empty band, where the find lands on position zero.
    directed.push_back(word_row(CMD_ALLOC, 0, 4, 0, 0));
    directed.push_back(word_row(CMD_ALLOC, 65535, 4096, 0, 0));
    directed.push_back(word_row(CMD_ALLOC, 4096, 0, 0, 0));
    directed.push_back(typed_row(word_row(CMD_WRITE, 0, 0, 8191, 255), '{0, 0, ST_OK, 0, 0}));
    // Four bands of 1024 sectors with a bitmap area and a short data zone.
    directed.push_back(reg_row(REG_BAND_COUNT, 4));
    directed.push_back(reg_row(REG_LOG2_BAND, 10));
    directed.push_back(reg_row(REG_ROOT, 100));
    directed.push_back(reg_row(REG_TOTAL, 3000));
    directed.push_back(reg_row(REG_BITMAP_AREA, 16));
    directed.push_back(reg_row(REG_INITIAL_FREE, 1000));
    directed.push_back(word_row(CMD_ALLOC, 50, 8, 0, 0));
    directed.push_back(word_row(CMD_ALLOC, 1027, 5, 0, 0));
    directed.push_back(word_row(CMD_ALLOC, 2990, 20, 0, 0));
    directed.push_back(word_row(CMD_ALLOC, 3001, 3, 0, 0));
    directed.push_back(word_row(CMD_ALLOC, 700, 2000, 0, 0));
    // A single one-byte band that is full leaves no space at all.
    directed.push_back(reg_row(REG_BAND_COUNT, 1));
    directed.push_back(reg_row(REG_LOG2_BAND, 3));
    directed.push_back(word_row(CMD_WRITE, 0, 0, 0, 255));
    directed.push_back(word_row(CMD_ALLOC, 5, 1, 0, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_reg) begin
        drain();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_word(directed[i].word, directed[i].typed, directed[i].result);
      end
    end

    // Random phases: each one starts with fresh register settings, the
    // extremes among them. The idling pattern moves through three modes.
    for (int phase = 0; phase < 12; phase++) begin
      drain();
      send_idle_pct = (phase < 4) ? 10 : (phase < 8) ? 49 : 0;
      recv_idle_pct = (phase < 4) ? 49 : (phase < 8) ? 10 : 0;
      write_reg(REG_BAND_COUNT, (phase % 4 != 0) ? 17'($urandom_range(1, 16)) :
                                (phase % 8 == 0) ? 17'd0 : 17'd31);
      write_reg(REG_LOG2_BAND, (phase == 5) ? 17'd15 : (phase == 3) ? 17'd0 :
                               17'($urandom_range(3, 6)));
      write_reg(REG_ROOT, (phase == 7) ? 17'd65535 : (phase == 1) ? 17'd0 :
                          17'($urandom_range(0, (eff_bands() << eff_log2()) / 4)));
      write_reg(REG_TOTAL, (phase == 9) ? 17'd1 : (phase == 2) ? 17'd65536 :
                17'($urandom_range((eff_bands() << eff_log2()) / 2,
                                   (eff_bands() << eff_log2()) + 8)));
      write_reg(REG_BITMAP_AREA, (phase == 10) ? 17'd4096 : 17'($urandom_range(0, 8)));
      write_reg(REG_INITIAL_FREE, (phase == 2) ? 17'd65536 : (phase == 4) ? 17'd0 :
                                  17'($urandom_range(0, 65536)));
      // The phase with the largest bands is slow to search, so it stays short.
      n_items = (phase == 5) ? 25 : 145;
      for (int k = 0; k < n_items; k++) begin
        if (phase == 1 && k == 60) hold_req = 1'b1;
        if (phase == 3 && k == 60) drain();
        w = random_word();
        send_word(w, 1'b0, '0);
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
